// File: hw/rtl/mck_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Morse character keyer package
// Shared types, register indexes, character codes and the Morse code table.
// ----------------------------------------------------------------------------
package mck_pkg;

  // Register widths and output widths
  localparam int unsigned DotMsW   = 10;
  localparam int unsigned DotsW    = 4;
  localparam int unsigned ToneW    = 12;
  localparam int unsigned SilenceW = 14;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned CfgIdxW  = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DOT_MS       = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SIGNAL_PAUSE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LETTER_PAUSE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_WORD_PAUSE   = 2'd3;

  // Register reset values
  localparam logic [DotMsW-1:0] DOT_MS_RST       = 10'd60;
  localparam logic [DotsW-1:0]  SIGNAL_PAUSE_RST = 4'd1;
  localparam logic [DotsW-1:0]  LETTER_PAUSE_RST = 4'd3;
  localparam logic [DotsW-1:0]  WORD_PAUSE_RST   = 4'd7;

  // Character codes
  localparam logic [CodeW-1:0] SPACE_CODE  = 8'd32;
  localparam logic [CodeW-1:0] TABLE_FIRST = 8'd39;
  localparam logic [CodeW-1:0] TABLE_LAST  = 8'd90;

  // Tone lengths in dots
  localparam logic [DotsW-1:0] DOT_DOTS  = 4'd1;
  localparam logic [DotsW-1:0] DASH_DOTS = 4'd3;

  // Configuration as seen by the sequencer
  typedef struct packed {
    logic [DotMsW-1:0] dot_ms;
    logic [DotsW-1:0]  signal_pause_dots;
    logic [DotsW-1:0]  letter_pause_dots;
    logic [DotsW-1:0]  word_pause_dots;
  } mck_cfg_t;

  // Entry per character: a start bit, then the signals, first signal highest
  // (1 is a dash, 0 a dot). A zero entry is an undefined character.
  localparam logic [7:0] MORSE_TABLE [52] = '{
    8'h5E, 8'h36, 8'h6D, 8'h19, 8'h2A, 8'h73, 8'h61, 8'h55, 8'h32, 8'h3F,
    8'h2F, 8'h27, 8'h23, 8'h21, 8'h20, 8'h30, 8'h38, 8'h3C, 8'h3E, 8'h78,
    8'h00, 8'h00, 8'h31, 8'h00, 8'h4C, 8'h5A, 8'h05, 8'h18, 8'h1A, 8'h0C,
    8'h02, 8'h12, 8'h0E, 8'h10, 8'h04, 8'h17, 8'h0D, 8'h14, 8'h07, 8'h06,
    8'h0F, 8'h16, 8'h1D, 8'h0A, 8'h08, 8'h03, 8'h09, 8'h11, 8'h0B, 8'h19,
    8'h1B, 8'h1C
  };

  // True for a code that the table covers
  function automatic logic in_table(input logic [CodeW-1:0] code);
    return (code >= TABLE_FIRST) && (code <= TABLE_LAST);
  endfunction

  // Table entry for a code inside the table range
  function automatic logic [7:0] morse_entry(input logic [CodeW-1:0] code);
    logic [CodeW-1:0] offs;
    offs = code - TABLE_FIRST;
    return MORSE_TABLE[offs[5:0]];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/morse_character_keyer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Morse character keyer
// A character's first word is built in the LOOK, TONE and SIL states after
// acceptance, and each further word in TONE and SIL after the previous one is taken.
// A new character is taken only once the last word of the previous one is taken;
// the one multiplier is shared between tone and silence of every word.
// Reset: the sequencer goes idle and the registers take their default values.
// ----------------------------------------------------------------------------
module morse_character_keyer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mck_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mck_pkg::DotMsW-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [mck_pkg::CodeW-1:0]    char_code_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [mck_pkg::ToneW-1:0]    tone_ms_o,
  output logic      [mck_pkg::SilenceW-1:0] silence_ms_o,
  output logic                              last_o
);
  import mck_pkg::*;

  mck_cfg_t            cfg_q;
  logic [DotsW-1:0]    mul_dots;
  logic [SilenceW-1:0] mul_ms;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_ms            <= DOT_MS_RST;
      cfg_q.signal_pause_dots <= SIGNAL_PAUSE_RST;
      cfg_q.letter_pause_dots <= LETTER_PAUSE_RST;
      cfg_q.word_pause_dots   <= WORD_PAUSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DOT_MS:       cfg_q.dot_ms            <= cfg_wdata_i;
        REG_SIGNAL_PAUSE: cfg_q.signal_pause_dots <= cfg_wdata_i[DotsW-1:0];
        REG_LETTER_PAUSE: cfg_q.letter_pause_dots <= cfg_wdata_i[DotsW-1:0];
        REG_WORD_PAUSE:   cfg_q.word_pause_dots   <= cfg_wdata_i[DotsW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Shared duration multiplier
  mck_mul u_mul (
    .dots_i   (mul_dots),
    .dot_ms_i (cfg_q.dot_ms),
    .ms_o     (mul_ms)
  );

  // Character sequencer
  mck_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tone_ms_o    (tone_ms_o),
    .silence_ms_o (silence_ms_o),
    .last_o       (last_o),
    .mul_dots_o   (mul_dots),
    .mul_ms_i     (mul_ms)
  );

endmodule
`default_nettype wire

// File: hw/rtl/mck_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Morse keyer duration multiplier
// Shared unit that turns a duration in dots into milliseconds.
// ----------------------------------------------------------------------------
module mck_mul (
  input  wire logic [mck_pkg::DotsW-1:0]    dots_i,
  input  wire logic [mck_pkg::DotMsW-1:0]   dot_ms_i,
  output logic      [mck_pkg::SilenceW-1:0] ms_o
);
  import mck_pkg::*;

  logic [DotsW+DotMsW-1:0] prod;

  // A 4 by 10 bit product; every legal result fits in the silence width.
  assign prod = {{DotMsW{1'b0}}, dots_i} * {{DotsW{1'b0}}, dot_ms_i};
  assign ms_o = prod[SilenceW-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/mck_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Morse keyer sequencer
// Looks a character up, walks its signal bits and builds each output word
// with two passes through the shared multiplier: tone first, then silence.
// ----------------------------------------------------------------------------
module mck_seq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mck_pkg::mck_cfg_t            cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [mck_pkg::CodeW-1:0]    char_code_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [mck_pkg::ToneW-1:0]    tone_ms_o,
  output logic      [mck_pkg::SilenceW-1:0] silence_ms_o,
  output logic                              last_o,
  output logic      [mck_pkg::DotsW-1:0]    mul_dots_o,
  input  wire logic [mck_pkg::SilenceW-1:0] mul_ms_i
);
  import mck_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_TONE = 3'd2;
  localparam logic [2:0] ST_SIL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CodeW-1:0]    code_q, code_d;
  logic [7:0]          entry_q, entry_d;
  logic [2:0]          rem_q, rem_d;
  logic                space_q, space_d;
  logic                last_q, last_d;
  logic [ToneW-1:0]    tone_q, tone_d;
  logic [SilenceW-1:0] sil_q, sil_d;
  logic [7:0]          lookup;
  logic [2:0]          msb_pos;
  logic [2:0]          bit_idx;

  // Position of the start bit; an empty entry yields no signals.
  always_comb begin
    lookup  = morse_entry(code_q);
    msb_pos = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (lookup[i]) begin
        msb_pos = 3'(i);
      end
    end
  end

  assign bit_idx = rem_q - 3'd1;

  // Factor handed to the shared multiplier in each step
  always_comb begin
    mul_dots_o = DOT_DOTS;
    if (state_q == ST_TONE) begin
      mul_dots_o = entry_q[bit_idx] ? DASH_DOTS : DOT_DOTS;
    end else if (state_q == ST_SIL) begin
      if (!last_q) begin
        mul_dots_o = cfg_i.signal_pause_dots;
      end else if (space_q) begin
        mul_dots_o = cfg_i.word_pause_dots;
      end else begin
        mul_dots_o = cfg_i.letter_pause_dots;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    entry_d = entry_q;
    rem_d   = rem_q;
    space_d = space_q;
    last_d  = last_q;
    tone_d  = tone_q;
    sil_d   = sil_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          code_d  = char_code_i;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        space_d = (code_q == SPACE_CODE);
        entry_d = lookup;
        rem_d   = msb_pos;
        if (code_q == SPACE_CODE) begin
          rem_d   = 3'd0;
          state_d = ST_TONE;
        end else if (in_table(code_q)) begin
          state_d = ST_TONE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TONE: begin
        if (space_q || (rem_q == 3'd0)) begin
          tone_d = '0;
          last_d = 1'b1;
        end else begin
          tone_d = mul_ms_i[ToneW-1:0];
          last_d = 1'b0;
        end
        state_d = ST_SIL;
      end
      ST_SIL: begin
        sil_d   = mul_ms_i;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            rem_d   = rem_q - 3'd1;
            state_d = ST_TONE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
      space_q <= 1'b0;
      rem_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      space_q <= space_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    entry_q <= entry_d;
    tone_q  <= tone_d;
    sil_q   <= sil_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = (state_q == ST_OUT);
  assign tone_ms_o    = tone_q;
  assign silence_ms_o = sil_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire
